// ===== hw/rtl/trl_pkg.sv =====
// Shared types and constants of the trace ring log buffer.
`timescale 1ns / 1ps
package trl_pkg;

   typedef enum logic [1:0] {
      OP_APPEND     = 2'd0,
      OP_DUMP_START = 2'd1,
      OP_DUMP_NEXT  = 2'd2,
      OP_CLEAR      = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_PENDING  = 3'd0,
      ST_ACCEPT   = 3'd1,
      ST_REJECT   = 3'd2,
      ST_DUMPBYTE = 3'd3,
      ST_DUMPEND  = 3'd4,
      ST_CLEARED  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_CHECK,
      CMD_SCAN_INIT,
      CMD_SCAN_READ,
      CMD_SCAN_STEP,
      CMD_SCAN_FOUND,
      CMD_EVICT_ALL,
      CMD_WRITE_INIT,
      CMD_WRITE_READ,
      CMD_WRITE_BYTE,
      CMD_WRITE_FINISH,
      CMD_DUMP_READ,
      CMD_DUMP_END,
      CMD_DUMP_HIT
   } cmd_type;

   typedef struct packed {
      logic reject;
      logic need_evict;
      logic scan_end;
      logic scan_match;
      logic write_done;
      logic dump_empty;
      logic dump_hit;
   } dp_status_type;

   localparam logic [7:0] MARKER_LAST = 8'h03;

   // Byte k of the record end marker 00 01 02 03.
   function automatic logic [7:0] marker_byte(input logic [1:0] k);
      return {6'b0, k};
   endfunction

endpackage

// ===== hw/rtl/trl_dpath.sv =====
// Datapath of the trace ring log buffer: stores, pointers, counters and scan logic.
`timescale 1ns / 1ps
module trl_dpath #(
   parameter int BUF_SIZE = 1024,
   parameter int CW = $clog2(BUF_SIZE + 1),
   parameter int IW = $clog2(BUF_SIZE / 5 + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  trl_pkg::cmd_type       cmd,
   input  logic [1:0]             req_op,
   input  logic [7:0]             req_byte,
   output trl_pkg::dp_status_type sts,
   output logic [2:0]             res_status,
   output logic [CW-1:0]          res_written,
   output logic [7:0]             res_byte,
   output logic [IW-1:0]          items,
   output logic [CW-1:0]          used
);
   import trl_pkg::*;

   localparam int AW = $clog2(BUF_SIZE);
   localparam logic [CW:0]   BUF_W = (CW + 1)'(BUF_SIZE);
   localparam logic [CW:0]   FOUR = (CW + 1)'(4);
   localparam logic [AW-1:0] LAST_P = AW'(BUF_SIZE - 1);

   logic [7:0] ring_mem [BUF_SIZE];
   logic [7:0] stage_mem [BUF_SIZE];

   logic [7:0]    ring_rd_ff, stage_rd_ff;
   logic [CW-1:0] stage_len_ff;
   logic          stage_end_ff;
   logic [AW-1:0] rd_ptr_ff, wr_ptr_ff, dcur_ff, scan_p_ff;
   logic [CW-1:0] used_ff, dleft_ff, scan_k_ff, clen_ff;
   logic [IW-1:0] items_ff;
   logic [7:0]    h0_ff, h1_ff, h2_ff;
   logic [CW:0]   wr_i_ff;
   logic [2:0]    status_ff;
   logic [CW-1:0] written_ff;
   logic [7:0]    byte_ff;

   logic [CW:0] len4, slen4, room;
   logic        in_body;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
      return (p == LAST_P) ? '0 : p + 1'b1;
   endfunction

   assign len4    = {1'b0, clen_ff} + FOUR;
   assign slen4   = {1'b0, stage_len_ff} + FOUR;
   assign room    = BUF_W - {1'b0, used_ff};
   assign in_body = wr_i_ff < {1'b0, clen_ff};

   always_comb begin
      sts.reject     = (stage_len_ff == '0) || (slen4 > BUF_W);
      sts.need_evict = (room < len4) && (used_ff != '0);
      sts.scan_end   = scan_k_ff == used_ff;
      sts.scan_match = (scan_k_ff >= CW'(3)) && (ring_rd_ff == MARKER_LAST)
                       && (h0_ff == marker_byte(2'd2)) && (h1_ff == marker_byte(2'd1))
                       && (h2_ff == marker_byte(2'd0));
      sts.write_done = wr_i_ff == len4;
      sts.dump_empty = dleft_ff == '0;
      sts.dump_hit   = ring_rd_ff > MARKER_LAST;
   end

   // Stores: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (cmd == CMD_SCAN_READ) begin
         ring_rd_ff <= ring_mem[scan_p_ff];
      end else if (cmd == CMD_DUMP_READ) begin
         ring_rd_ff <= ring_mem[dcur_ff];
      end
      if (cmd == CMD_WRITE_BYTE) begin
         ring_mem[wr_ptr_ff] <= in_body ? stage_rd_ff
                                        : marker_byte(wr_i_ff[1:0] - clen_ff[1:0]);
      end
      if (cmd == CMD_WRITE_READ) begin
         stage_rd_ff <= stage_mem[wr_i_ff[AW-1:0]];
      end
      if (cmd == CMD_ACCEPT && req_op == OP_APPEND && !stage_end_ff && req_byte != 8'h00
          && stage_len_ff < BUF_W[CW-1:0]) begin
         stage_mem[stage_len_ff[AW-1:0]] <= req_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_len_ff <= '0;
         stage_end_ff <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         used_ff      <= '0;
         items_ff     <= '0;
         dcur_ff      <= '0;
         dleft_ff     <= '0;
      end else begin
         case (cmd)
            CMD_ACCEPT: begin
               status_ff  <= (req_op == OP_CLEAR) ? ST_CLEARED : ST_PENDING;
               written_ff <= '0;
               byte_ff    <= '0;
               case (req_op)
                  OP_APPEND: begin
                     if (!stage_end_ff) begin
                        if (req_byte == 8'h00) begin
                           stage_end_ff <= 1'b1;
                        end else if (stage_len_ff < BUF_W[CW-1:0]) begin
                           stage_len_ff <= stage_len_ff + 1'b1;
                        end
                     end
                  end
                  OP_DUMP_START: begin
                     dcur_ff  <= rd_ptr_ff;
                     dleft_ff <= used_ff;
                  end
                  OP_CLEAR: begin
                     stage_len_ff <= '0;
                     stage_end_ff <= 1'b0;
                     rd_ptr_ff    <= '0;
                     wr_ptr_ff    <= '0;
                     used_ff      <= '0;
                     items_ff     <= '0;
                     dcur_ff      <= '0;
                     dleft_ff     <= '0;
                  end
                  default: begin
                  end
               endcase
            end
            CMD_CHECK: begin
               clen_ff      <= stage_len_ff;
               stage_len_ff <= '0;
               stage_end_ff <= 1'b0;
               if (sts.reject) begin
                  status_ff <= ST_REJECT;
               end
            end
            CMD_SCAN_INIT: begin
               scan_p_ff <= rd_ptr_ff;
               scan_k_ff <= '0;
            end
            CMD_SCAN_STEP: begin
               h2_ff     <= h1_ff;
               h1_ff     <= h0_ff;
               h0_ff     <= ring_rd_ff;
               scan_p_ff <= ring_next(scan_p_ff);
               scan_k_ff <= scan_k_ff + 1'b1;
            end
            CMD_SCAN_FOUND: begin
               rd_ptr_ff <= ring_next(scan_p_ff);
               used_ff   <= used_ff - scan_k_ff - 1'b1;
               if (items_ff != '0) begin
                  items_ff <= items_ff - 1'b1;
               end
            end
            CMD_EVICT_ALL: begin
               rd_ptr_ff <= wr_ptr_ff;
               used_ff   <= '0;
               items_ff  <= '0;
            end
            CMD_WRITE_INIT: begin
               wr_i_ff <= '0;
            end
            CMD_WRITE_BYTE: begin
               wr_ptr_ff <= ring_next(wr_ptr_ff);
               wr_i_ff   <= wr_i_ff + 1'b1;
            end
            CMD_WRITE_FINISH: begin
               used_ff    <= used_ff + len4[CW-1:0];
               items_ff   <= items_ff + 1'b1;
               status_ff  <= ST_ACCEPT;
               written_ff <= len4[CW-1:0];
            end
            CMD_DUMP_READ: begin
               dcur_ff  <= ring_next(dcur_ff);
               dleft_ff <= dleft_ff - 1'b1;
            end
            CMD_DUMP_END: begin
               status_ff <= ST_DUMPEND;
            end
            CMD_DUMP_HIT: begin
               status_ff <= ST_DUMPBYTE;
               byte_ff   <= ring_rd_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign res_status  = status_ff;
   assign res_written = written_ff;
   assign res_byte    = byte_ff;
   assign items       = items_ff;
   assign used        = used_ff;

endmodule

// ===== hw/rtl/trl_ctrl.sv =====
// Controller state machine of the trace ring log buffer.
`timescale 1ns / 1ps
module trl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_op,
   input  logic                   req_last,
   input  logic                   rsp_ready,
   input  trl_pkg::dp_status_type sts,
   output trl_pkg::cmd_type       cmd,
   output logic                   req_ready,
   output logic                   rsp_valid,
   output logic                   out_load
);
   import trl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_EVICT_TEST, S_SCAN_INIT, S_SCAN_READ, S_SCAN_CHECK,
      S_WRITE_INIT, S_WRITE_READ, S_WRITE_BYTE, S_DUMP_READ, S_DUMP_CHECK, S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_NONE;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd = CMD_ACCEPT;
               case (req_op)
                  OP_APPEND:     state_in = req_last ? S_CHECK : S_RESULT;
                  OP_DUMP_START: state_in = S_DUMP_READ;
                  OP_DUMP_NEXT:  state_in = S_DUMP_READ;
                  default:       state_in = S_RESULT;
               endcase
            end
         end
         S_CHECK: begin
            cmd      = CMD_CHECK;
            state_in = sts.reject ? S_RESULT : S_EVICT_TEST;
         end
         S_EVICT_TEST: begin
            state_in = sts.need_evict ? S_SCAN_INIT : S_WRITE_INIT;
         end
         S_SCAN_INIT: begin
            cmd      = CMD_SCAN_INIT;
            state_in = S_SCAN_READ;
         end
         S_SCAN_READ: begin
            if (sts.scan_end) begin
               cmd      = CMD_EVICT_ALL;
               state_in = S_EVICT_TEST;
            end else begin
               cmd      = CMD_SCAN_READ;
               state_in = S_SCAN_CHECK;
            end
         end
         S_SCAN_CHECK: begin
            if (sts.scan_match) begin
               cmd      = CMD_SCAN_FOUND;
               state_in = S_EVICT_TEST;
            end else begin
               cmd      = CMD_SCAN_STEP;
               state_in = S_SCAN_READ;
            end
         end
         S_WRITE_INIT: begin
            cmd      = CMD_WRITE_INIT;
            state_in = S_WRITE_READ;
         end
         S_WRITE_READ: begin
            if (sts.write_done) begin
               cmd      = CMD_WRITE_FINISH;
               state_in = S_RESULT;
            end else begin
               cmd      = CMD_WRITE_READ;
               state_in = S_WRITE_BYTE;
            end
         end
         S_WRITE_BYTE: begin
            cmd      = CMD_WRITE_BYTE;
            state_in = S_WRITE_READ;
         end
         S_DUMP_READ: begin
            if (sts.dump_empty) begin
               cmd      = CMD_DUMP_END;
               state_in = S_RESULT;
            end else begin
               cmd      = CMD_DUMP_READ;
               state_in = S_DUMP_CHECK;
            end
         end
         S_DUMP_CHECK: begin
            if (sts.dump_hit) begin
               cmd      = CMD_DUMP_HIT;
               state_in = S_RESULT;
            end else begin
               state_in = S_DUMP_READ;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/trace_ring_log_buffer.sv =====
// Top level of the trace ring log buffer: stream ports, result register and checks.
`timescale 1ns / 1ps
// An append byte that does not end a message goes from acceptance to the result state.
// Such steps take the item in the idle state, then load the result in the result state.
// A commit passes read and write states per stored byte, plus read and check states per scanned byte during eviction.
// A dump step reads ring bytes one at a time through read and check states, markers skipped included.
// One item is worked on at a time; the next is taken while a result waits in the output.
// Synchronous active-high reset empties the ring; the stores hold no reset value.
module trace_ring_log_buffer #(
   parameter int BUF_SIZE = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic [1:0]   req_tuser,   // opcode
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // written_len, out_byte, record_count, used_bytes, zero padding
   output logic [((2 * $clog2(BUF_SIZE + 1) + 16 + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [2:0]   rsp_tuser    // status
);
   import trl_pkg::*;

   localparam int CW = $clog2(BUF_SIZE + 1);
   localparam int IW = $clog2(BUF_SIZE / 5 + 1);
   localparam int DW = ((2 * CW + 16 + 7) / 8) * 8;
   localparam int PW = DW - (2 * CW + 16);

   cmd_type       cmd;
   dp_status_type sts;
   logic          out_load;
   logic [2:0]    res_status;
   logic [CW-1:0] res_written, used;
   logic [7:0]    res_byte;
   logic [IW-1:0] items;
   logic [IW+7:0] items_ext;

   logic [2:0]    status_ff;
   logic [CW-1:0] written_ff, used_ff;
   logic [7:0]    byte_ff, count_ff;

   trl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_last  (req_tlast),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .out_load  (out_load)
   );

   trl_dpath #(
      .BUF_SIZE (BUF_SIZE),
      .CW       (CW),
      .IW       (IW)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_op      (req_tuser),
      .req_byte    (req_tdata),
      .sts         (sts),
      .res_status  (res_status),
      .res_written (res_written),
      .res_byte    (res_byte),
      .items       (items),
      .used        (used)
   );

   assign items_ext = {8'b0, items};

   // The result register frees the controller while the consumer stalls.
   always_ff @(posedge clock) begin
      if (out_load) begin
         status_ff  <= res_status;
         written_ff <= res_written;
         byte_ff    <= res_byte;
         count_ff   <= items_ext[7:0];
         used_ff    <= used;
      end
   end

   assign rsp_tuser = status_ff;
   assign rsp_tdata = {{PW{1'b0}}, used_ff, count_ff, byte_ff, written_ff};

   // The ring never reports more used bytes than its size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, used_ff} <= (CW + 1)'(BUF_SIZE))
      else $error("used bytes beyond ring size");

   // An accepted record always carries its marker length.
   a_accept_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff == ST_ACCEPT |-> written_ff >= CW'(5))
      else $error("accepted record too short");

   // Only an accept reports a written length.
   a_written_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff != ST_ACCEPT |-> written_ff == '0)
      else $error("written length outside accept");

   // A dumped byte is never a marker value.
   a_dump_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status_ff == ST_DUMPBYTE |-> byte_ff > MARKER_LAST)
      else $error("marker byte dumped");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the trace ring log buffer.
`timescale 1ns / 1ps
module tb;
   import trl_pkg::*;

   localparam int RING_BYTES = 1024;
   localparam int STALL_LIMIT = 40000;

   typedef struct {
      opcode_type op;
      logic [7:0] data;
      logic       last;
   } log_item_type;

   typedef struct {
      status_type  st;
      logic [10:0] wlen;
      logic [7:0]  ob;
      logic [7:0]  rc;
      logic [10:0] ub;
   } log_answer_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic [1:0]  req_tuser = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   trace_ring_log_buffer #(.BUF_SIZE(RING_BYTES)) dut (.*);

   // Shadow of the ring, the staging area and the pointers.
   logic [7:0]  ring_mem [RING_BYTES];
   logic [7:0]  stage_mem [RING_BYTES];
   int          stage_cnt, rd_ptr, wr_ptr, used_cnt, rec_cnt, dump_pos, dump_rem;
   bit          stage_done;

   log_item_type   pending_items [$];
   log_answer_type expected_answers [$];
   log_item_type   cur;
   int             sent, total, errors, quiet_cycles, phase;
   bit             paused;

   initial forever #2 clock = ~clock;

   function automatic int nx(input int p);
      return (p + 1 >= RING_BYTES) ? 0 : p + 1;
   endfunction

   // Drop the oldest record: scan for the end marker within the used bytes.
   function automatic void drop_oldest();
      int p, n;
      p = rd_ptr;
      n = 0;
      while (n < used_cnt) begin
         if (ring_mem[p] == 0 && n + 4 <= used_cnt && ring_mem[nx(p)] == 1
             && ring_mem[nx(nx(p))] == 2 && ring_mem[nx(nx(nx(p)))] == 3) begin
            rd_ptr = nx(nx(nx(nx(p))));
            used_cnt -= n + 4;
            if (rec_cnt > 0) rec_cnt--;
            return;
         end
         p = nx(p);
         n++;
      end
      rd_ptr = wr_ptr;
      used_cnt = 0;
      rec_cnt = 0;
   endfunction

   function automatic status_type dump_advance(output logic [7:0] ob);
      logic [7:0] v;
      ob = 0;
      while (dump_rem > 0) begin
         v = ring_mem[dump_pos];
         dump_pos = nx(dump_pos);
         dump_rem--;
         if (v > MARKER_LAST) begin
            ob = v;
            return ST_DUMPBYTE;
         end
      end
      return ST_DUMPEND;
   endfunction

   // Applies one accepted item to the shadow state and queues its answer.
   function automatic void predict_answer(input log_item_type it);
      log_answer_type a;
      int len;
      a.st = ST_PENDING;
      a.wlen = 0;
      a.ob = 0;
      case (it.op)
         OP_APPEND: begin
            if (!stage_done) begin
               if (it.data == 0) begin
                  stage_done = 1;
               end else if (stage_cnt < RING_BYTES) begin
                  stage_mem[stage_cnt] = it.data;
                  stage_cnt = stage_cnt + 1;
               end
            end
            if (it.last) begin
               len = stage_cnt;
               stage_cnt = 0;
               stage_done = 0;
               if (len == 0 || len + 4 > RING_BYTES) begin
                  a.st = ST_REJECT;
               end else begin
                  while (RING_BYTES - used_cnt < len + 4 && used_cnt > 0) drop_oldest();
                  for (int i = 0; i < len + 4; i++) begin
                     ring_mem[wr_ptr] = (i < len) ? stage_mem[i] : 8'(i - len);
                     wr_ptr = nx(wr_ptr);
                  end
                  used_cnt += len + 4;
                  rec_cnt++;
                  a.st = ST_ACCEPT;
                  a.wlen = 11'(len + 4);
               end
            end
         end
         OP_DUMP_START: begin
            dump_pos = rd_ptr;
            dump_rem = used_cnt;
            a.st = dump_advance(a.ob);
         end
         OP_DUMP_NEXT: a.st = dump_advance(a.ob);
         default: begin
            foreach (ring_mem[i]) ring_mem[i] = 0;
            rd_ptr = 0;
            wr_ptr = 0;
            used_cnt = 0;
            rec_cnt = 0;
            dump_pos = 0;
            dump_rem = 0;
            stage_cnt = 0;
            stage_done = 0;
            a.st = ST_CLEARED;
         end
      endcase
      a.rc = 8'(rec_cnt);
      a.ub = 11'(used_cnt);
      expected_answers.push_back(a);
   endfunction

   task automatic add_item(input opcode_type op, input logic [7:0] d, input logic l);
      log_item_type it;
      it.op = op;
      it.data = d;
      it.last = l;
      pending_items.push_back(it);
   endtask

   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 3) return 0;
      if (r < 8) return 8'($urandom_range(3, 1));
      return 8'($urandom_range(255, 4));
   endfunction

   // A message of the given length; random bytes that may be zero or marker values.
   task automatic add_message(input int len);
      for (int i = 0; i < len; i++) add_item(OP_APPEND, text_byte(), i == len - 1);
   endtask

   // Stimulus: a directed opening, large records, then random messages, dumps, clears and open fragments.
   initial begin
      int r, n;
      add_item(OP_DUMP_NEXT, 8'hFF, 1);          // dump next with nothing started
      add_item(OP_DUMP_START, 8'h00, 1);         // dump of an empty ring
      add_item(OP_APPEND, 8'h00, 1);             // empty message is rejected
      add_item(OP_APPEND, 8'hFF, 0);
      add_item(OP_APPEND, 8'h04, 1);             // two byte message
      add_item(OP_APPEND, 8'h41, 0);
      add_item(OP_APPEND, 8'h00, 0);             // zero ends the string
      add_item(OP_APPEND, 8'h42, 0);             // dropped
      add_item(OP_APPEND, 8'h43, 1);             // dropped, still commits
      add_item(OP_APPEND, 8'h02, 1);             // marker-valued text byte
      add_item(OP_DUMP_START, 8'hAA, 0);
      for (int i = 0; i < 4; i++) add_item(OP_DUMP_NEXT, 8'h55, i[0]);
      add_item(OP_APPEND, 8'h7E, 0);             // append in the middle of a dump
      add_item(OP_DUMP_NEXT, 8'h00, 0);
      add_item(OP_APPEND, 8'h80, 1);
      add_item(OP_DUMP_NEXT, 8'h00, 0);
      add_item(OP_APPEND, 8'h99, 0);             // pending message lost on clear
      add_item(OP_CLEAR, 8'hFF, 1);
      add_item(OP_DUMP_NEXT, 8'h00, 0);
      // Large records that nearly fill the ring, so that the next ones evict old records.
      add_message(300);
      add_message(400);
      add_message(250);
      add_message(3);
      while (pending_items.size() < 1000) begin
         r = $urandom_range(99);
         if (r < 60) add_message($urandom_range(12, 1));
         else if (r < 64) add_message($urandom_range(200, 50));
         else if (r < 86) begin
            add_item(OP_DUMP_START, 8'($urandom), 1'($urandom));
            n = $urandom_range(10);
            for (int i = 0; i < n; i++) add_item(OP_DUMP_NEXT, 8'($urandom), 1'($urandom));
         end else if (r < 89) add_item(OP_CLEAR, 8'($urandom), 1'($urandom));
         else add_item(OP_APPEND, text_byte(), 0);  // fragment left open
      end
      total = pending_items.size();
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
   end

   // Idling phases by progress: none, sender idle, receiver stall, both light.
   assign phase = (total == 0) ? 0 : (sent * 4) / total;

   always @(posedge clock) begin
      bit go;
      int idle;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_answer(cur);
            sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            idle = (phase == 1) ? 64 : (phase == 3) ? 9 : 0;
            go = pending_items.size() > 0 && $urandom_range(99) >= idle;
            // Once, midway, hold back until all answers are in.
            if (!paused && sent >= total / 2 && total > 0) begin
               go = 0;
               if (expected_answers.size() == 0) paused = 1;
            end
            if (go) begin
               cur = pending_items.pop_front();
               req_tuser <= cur.op;
               req_tdata <= cur.data;
               req_tlast <= cur.last;
            end
            req_tvalid <= go;
         end
      end
   end

   always @(posedge clock) begin
      log_answer_type e;
      int stall;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected answer, status %0d", rsp_tuser);
               errors++;
            end else begin
               e = expected_answers.pop_front();
               if (rsp_tuser != e.st) begin
                  $error("status: expected %0d, got %0d", e.st, rsp_tuser); errors++;
               end
               if (rsp_tdata[10:0] != e.wlen) begin
                  $error("written_len: expected %0d, got %0d", e.wlen, rsp_tdata[10:0]);
                  errors++;
               end
               if (rsp_tdata[18:11] != e.ob) begin
                  $error("out_byte: expected %0d, got %0d", e.ob, rsp_tdata[18:11]);
                  errors++;
               end
               if (rsp_tdata[26:19] != e.rc) begin
                  $error("record_count: expected %0d, got %0d", e.rc, rsp_tdata[26:19]);
                  errors++;
               end
               if (rsp_tdata[37:27] != e.ub) begin
                  $error("used_bytes: expected %0d, got %0d", e.ub, rsp_tdata[37:27]);
                  errors++;
               end
            end
         end
         stall = (phase == 2) ? 64 : (phase == 3) ? 9 : 0;
         rsp_tready <= $urandom_range(99) >= stall;
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("trace_ring_log_buffer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (total > 0);
      do @(posedge clock);
      while (pending_items.size() > 0 || req_tvalid || expected_answers.size() > 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("trace_ring_log_buffer verification clean");
      end else begin
         $display("trace_ring_log_buffer verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/trl_pkg.sv
hw/rtl/trl_dpath.sv
hw/rtl/trl_ctrl.sv
hw/rtl/trace_ring_log_buffer.sv
sim/tb.sv
